/* hdl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants for the PNG scanline unfilter: register indexes, filter
// type codes, field widths and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package psu_pkg;

  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 15;
  localparam int ROW_BYTES_W   = 15;
  localparam int PIXEL_BYTES_W = 4;
  localparam int BYTE_W        = 8;

  localparam int DEF_MAX_ROW_BYTES   = 16384;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BYTES = CFG_IDX_W'(1);

  localparam logic [ROW_BYTES_W-1:0]   ROW_BYTES_RST   = ROW_BYTES_W'(1);
  localparam logic [PIXEL_BYTES_W-1:0] PIXEL_BYTES_RST = PIXEL_BYTES_W'(1);

  localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
  localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
  localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
  localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
  localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

endpackage

`default_nettype wire

/* hdl/psu_if.sv */
// ----------------------------------------------------------------------------
// psu_if
// Handshake channels of the scanline unfilter: filtered byte input,
// reconstructed byte output and register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface psu_in_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first_of_image;
  modport source (output valid, output data_byte, output first_of_image, input ready);
  modport sink   (input valid, input data_byte, input first_of_image, output ready);
endinterface

interface psu_out_if;
  import psu_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] recon_byte;
  logic              row_end;
  modport source (output valid, output recon_byte, output row_end, input ready);
  modport sink   (input valid, input recon_byte, input row_end, output ready);
endinterface

interface psu_cfg_if;
  import psu_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hdl/psu_line_buf.sv */
// ----------------------------------------------------------------------------
// psu_line_buf
// Previous-row line buffer: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_line_buf #(
  parameter int DEPTH = psu_pkg::DEF_MAX_ROW_BYTES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [AW-1:0]             waddr_i,
  input  wire logic [psu_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic                      re_i,
  input  wire logic [AW-1:0]             raddr_i,
  output logic      [psu_pkg::BYTE_W-1:0] rdata_o
);
  import psu_pkg::*;

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/psu_recon.sv */
// ----------------------------------------------------------------------------
// psu_recon
// Byte reconstruction for filters None, Sub, Up, Average and Paeth.
// ----------------------------------------------------------------------------
`default_nettype none

module psu_recon (
  input  wire logic [psu_pkg::BYTE_W-1:0] kind_i,
  input  wire logic [psu_pkg::BYTE_W-1:0] x_i,
  input  wire logic [psu_pkg::BYTE_W-1:0] a_i,
  input  wire logic [psu_pkg::BYTE_W-1:0] b_i,
  input  wire logic [psu_pkg::BYTE_W-1:0] c_i,
  output logic      [psu_pkg::BYTE_W-1:0] r_o
);
  import psu_pkg::*;

  logic signed [BYTE_W+1:0] sa, sb, sc, da, db, dc;
  logic        [BYTE_W+1:0] pa, pb, pc;
  logic        [BYTE_W-1:0] pred;
  logic        [BYTE_W:0]   avg_sum;

  always_comb begin
    sa = $signed({2'b00, a_i});
    sb = $signed({2'b00, b_i});
    sc = $signed({2'b00, c_i});
    // p - a = b - c, p - b = a - c, p - c = a + b - 2c
    da = sb - sc;
    db = sa - sc;
    dc = sa + sb - sc - sc;
    pa = (da < 0) ? $unsigned(-da) : $unsigned(da);
    pb = (db < 0) ? $unsigned(-db) : $unsigned(db);
    pc = (dc < 0) ? $unsigned(-dc) : $unsigned(dc);
    avg_sum = {1'b0, a_i} + {1'b0, b_i};
    unique case (kind_i)
      FILT_SUB:   pred = a_i;
      FILT_UP:    pred = b_i;
      FILT_AVG:   pred = avg_sum[BYTE_W:1];
      FILT_PAETH: begin
        priority if (pa <= pb && pa <= pc) begin
          pred = a_i;
        end else if (pb <= pc) begin
          pred = b_i;
        end else begin
          pred = c_i;
        end
      end
      default:    pred = '0;
    endcase
    r_o = x_i + pred;
  end

endmodule

`default_nettype wire

/* hdl/png_scanline_unfilter_unit.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit
// PNG row filter reconstruction with a previous-row line buffer.
//
//   channel  dir  word                          accepted when
//   in_i     in   data_byte, first_of_image     valid && ready
//   out_o    out  recon_byte, row_end           valid && ready
//   cfg_i    in   index, data                   valid (ready tied high)
//
// One byte per cycle unless out_o stalls; data bytes pass the reconstruct
// stage and output registers. Line buffer read is issued at acceptance,
// write-back happens as the byte leaves the reconstruct stage. Filter bytes
// give no word. Reset clears control only; the line buffer is not cleared.
// A stall on out_o holds the reconstruct stage and then drops in_i.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module png_scanline_unfilter_unit #(
  parameter int MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psu_in_if.sink    in_i,
  psu_out_if.source out_o,
  psu_cfg_if.sink   cfg_i
);
  import psu_pkg::*;

  localparam int PW  = $clog2(MAX_ROW_BYTES);
  localparam int RBW = ($clog2(MAX_ROW_BYTES + 1) > ROW_BYTES_W) ?
                       $clog2(MAX_ROW_BYTES + 1) : ROW_BYTES_W;
  localparam int CW  = RBW + 1;
  localparam int HW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int IW  = HW + 1;

  // registers
  logic [ROW_BYTES_W-1:0]   row_bytes_q;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes_q;

  // row control
  logic [BYTE_W-1:0] kind_q, kind_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [HW-1:0]     hidx_q, hidx_d;
  logic              expect_q, expect_d;
  logic              first_row_q, first_row_d;

  // reconstruct stage
  logic              s2_valid_q;
  logic [BYTE_W-1:0] s2_x_q, s2_kind_q;
  logic [PW-1:0]     s2_pos_q;
  logic [HW-1:0]     s2_hidx_q;
  logic              s2_bzero_q, s2_end_q;

  // output register
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_end_q;

  logic [BYTE_W-1:0] left_hist_q [MAX_PIXEL_BYTES];
  logic [BYTE_W-1:0] up_hist_q   [MAX_PIXEL_BYTES];

  logic                     s2_adv, in_acc, is_filter, acc_data, row_done;
  logic [CW-1:0]            rb_eff, pos_next;
  logic [PIXEL_BYTES_W-1:0] pix_dist;
  logic [IW-1:0]            hx, dx, ridx_w;
  logic [HW-1:0]            ridx;
  logic                     have_left;
  logic [BYTE_W-1:0]        mem_rd, a_val, b_val, c_val, r_val;

  assign s2_adv    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s2_valid_q || s2_adv;
  assign in_acc    = in_i.valid && in_i.ready;
  assign is_filter = in_i.first_of_image || expect_q;
  assign acc_data  = in_acc && !is_filter;

  always_comb begin
    if (row_bytes_q == '0) begin
      rb_eff = CW'(1);
    end else if (CW'(row_bytes_q) > CW'(MAX_ROW_BYTES)) begin
      rb_eff = CW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CW'(row_bytes_q);
    end
    pos_next = CW'(pos_q) + CW'(1);
    row_done = (pos_next >= rb_eff);
  end

  always_comb begin
    kind_d      = kind_q;
    pos_d       = pos_q;
    hidx_d      = hidx_q;
    expect_d    = expect_q;
    first_row_d = first_row_q;
    if (in_acc) begin
      if (is_filter) begin
        kind_d   = in_i.data_byte;
        pos_d    = '0;
        hidx_d   = '0;
        expect_d = 1'b0;
        if (in_i.first_of_image) begin
          first_row_d = 1'b1;
        end
      end else if (row_done) begin
        pos_d       = '0;
        hidx_d      = '0;
        expect_d    = 1'b1;
        first_row_d = 1'b0;
      end else begin
        pos_d  = pos_next[PW-1:0];
        hidx_d = (hidx_q == HW'(MAX_PIXEL_BYTES - 1)) ? '0 : hidx_q + HW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q      <= FILT_NONE;
      pos_q       <= '0;
      hidx_q      <= '0;
      expect_q    <= 1'b1;
      first_row_q <= 1'b1;
    end else begin
      kind_q      <= kind_d;
      pos_q       <= pos_d;
      hidx_q      <= hidx_d;
      expect_q    <= expect_d;
      first_row_q <= first_row_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= ROW_BYTES_RST;
      pixel_bytes_q <= PIXEL_BYTES_RST;
    end else if (cfg_i.valid) begin
      priority if (cfg_i.index == REG_ROW_BYTES) begin
        row_bytes_q <= cfg_i.data[ROW_BYTES_W-1:0];
      end else if (cfg_i.index == REG_PIXEL_BYTES) begin
        pixel_bytes_q <= cfg_i.data[PIXEL_BYTES_W-1:0];
      end else begin
        row_bytes_q <= row_bytes_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (acc_data) begin
      s2_valid_q <= 1'b1;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_data) begin
      s2_x_q     <= in_i.data_byte;
      s2_kind_q  <= kind_q;
      s2_pos_q   <= pos_q;
      s2_hidx_q  <= hidx_q;
      s2_bzero_q <= first_row_q;
      s2_end_q   <= row_done;
    end
  end

  psu_line_buf #(
    .DEPTH (MAX_ROW_BYTES),
    .AW    (PW)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q && s2_adv),
    .waddr_i (s2_pos_q),
    .wdata_i (r_val),
    .re_i    (acc_data),
    .raddr_i (pos_q),
    .rdata_o (mem_rd)
  );

  always_comb begin
    if (pixel_bytes_q == '0) begin
      pix_dist = PIXEL_BYTES_W'(1);
    end else if (pixel_bytes_q > PIXEL_BYTES_W'(MAX_PIXEL_BYTES)) begin
      pix_dist = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    end else begin
      pix_dist = pixel_bytes_q;
    end
    have_left = (CW'(s2_pos_q) >= CW'(pix_dist));
    hx = {1'b0, s2_hidx_q};
    dx = IW'(pix_dist);
    ridx_w = (hx >= dx) ? (hx - dx) : (hx + IW'(MAX_PIXEL_BYTES) - dx);
    ridx = ridx_w[HW-1:0];
    b_val = s2_bzero_q ? '0 : mem_rd;
    a_val = have_left ? left_hist_q[ridx] : '0;
    c_val = have_left ? up_hist_q[ridx] : '0;
  end

  psu_recon u_recon (
    .kind_i (s2_kind_q),
    .x_i    (s2_x_q),
    .a_i    (a_val),
    .b_i    (b_val),
    .c_i    (c_val),
    .r_o    (r_val)
  );

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s2_adv) begin
      left_hist_q[s2_hidx_q] <= r_val;
      up_hist_q[s2_hidx_q]   <= b_val;
      out_byte_q             <= r_val;
      out_end_q              <= s2_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.recon_byte = out_byte_q;
  assign out_o.row_end    = out_end_q;

endmodule

`default_nettype wire

/* verif/png_scanline_unfilter_unit_test.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter_unit_test
// Self-checking bench for the PNG scanline unfilter. Streams filter-type and
// data bytes through the input channel with random gaps and output
// back-pressure, rewrites row length and pixel distance between phases, and
// compares every reconstructed word field by field with a local predictor.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psu_pkg::*;

  localparam int LINE_DEPTH    = DEF_MAX_ROW_BYTES;
  localparam int HIST_DEPTH    = DEF_MAX_PIXEL_BYTES;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_ERR_LINES = 200;
  localparam int LONG_ROW_PART = 100;
  localparam int PHASE_ITEMS   = 65;

  localparam logic [BYTE_W-1:0]    FILT_TOP_CODE = '1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_IDX  = '1;

  typedef struct packed {
    logic              first;
    logic [BYTE_W-1:0] data;
  } scan_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] recon;
    logic              row_end;
  } recon_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  psu_in_if  in_if ();
  psu_out_if out_if ();
  psu_cfg_if cfg_if ();

  png_scanline_unfilter_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [BYTE_W-1:0]        line_buf [LINE_DEPTH];
  logic [BYTE_W-1:0]        left_win [HIST_DEPTH];
  logic [BYTE_W-1:0]        up_win   [HIST_DEPTH];
  logic [BYTE_W-1:0]        cur_filter;
  logic [ROW_BYTES_W-1:0]   row_bytes_reg;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes_reg;
  int unsigned              col;
  int unsigned              buf_filled;
  bit                       await_filter;
  bit                       top_row;

  scan_word_t  pending_words [$];
  recon_word_t recon_q [$];

  bit          in_fire;
  int unsigned idle_cycles;
  int unsigned err_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  function automatic int unsigned eff_row_len(logic [ROW_BYTES_W-1:0] n);
    if (n == 0) return 1;
    if (n > LINE_DEPTH) return LINE_DEPTH;
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] paeth_pick(int a, int b, int c);
    int p, pa, pb, pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) return BYTE_W'(a);
    if (pb <= pc) return BYTE_W'(b);
    return BYTE_W'(c);
  endfunction

  function automatic logic [BYTE_W-1:0] pick_filter();
    if ($urandom_range(0, 6) != 0) return BYTE_W'($urandom_range(FILT_NONE, FILT_PAETH));
    return BYTE_W'($urandom_range(FILT_PAETH + 1, FILT_TOP_CODE));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic clear_windows();
    foreach (left_win[i]) begin
      left_win[i] = '0;
      up_win[i]   = '0;
    end
  endtask

  task automatic predict_word(scan_word_t w);
    int unsigned       rlen, pdist, pos;
    int                a, b, c;
    logic [BYTE_W-1:0] r;
    recon_word_t       e;
    if (w.first) begin
      await_filter = 1'b1;
      top_row      = 1'b1;
      col          = 0;
      clear_windows();
    end
    if (await_filter) begin
      cur_filter   = w.data;
      col          = 0;
      await_filter = 1'b0;
      return;
    end
    rlen  = eff_row_len(row_bytes_reg);
    pdist = (pixel_bytes_reg == 0) ? 1 :
            (pixel_bytes_reg > HIST_DEPTH) ? HIST_DEPTH : pixel_bytes_reg;
    pos   = col % LINE_DEPTH;
    a = 0;
    b = 0;
    c = 0;
    if (!top_row) b = line_buf[pos];
    if (pos >= pdist) begin
      a = left_win[(pos - pdist) % HIST_DEPTH];
      c = up_win[(pos - pdist) % HIST_DEPTH];
    end
    case (cur_filter)
      FILT_SUB:   r = BYTE_W'(int'(w.data) + a);
      FILT_UP:    r = BYTE_W'(int'(w.data) + b);
      FILT_AVG:   r = BYTE_W'(int'(w.data) + ((a + b) >> 1));
      FILT_PAETH: r = w.data + paeth_pick(a, b, c);
      default:    r = w.data;
    endcase
    up_win[pos % HIST_DEPTH]   = BYTE_W'(b);
    left_win[pos % HIST_DEPTH] = r;
    line_buf[pos]              = r;
    if (pos + 1 > buf_filled) buf_filled = pos + 1;
    e.recon   = r;
    e.row_end = (pos + 1 >= rlen);
    recon_q.push_back(e);
    if (e.row_end) begin
      await_filter = 1'b1;
      top_row      = 1'b0;
      col          = 0;
      clear_windows();
    end else begin
      col = pos + 1;
    end
  endtask

  task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
    err_count++;
    if (err_count <= MAX_ERR_LINES)
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // monitor: sample everything at the rising edge
  always @(posedge clk_i) begin
    recon_word_t e;
    bit          out_fire, cfg_fire;
    in_fire  = rst_ni && in_if.valid && in_if.ready;
    out_fire = rst_ni && out_if.valid && out_if.ready;
    cfg_fire = rst_ni && cfg_if.valid && cfg_if.ready;
    if (rst_ni) begin
      if (in_fire) predict_word({in_if.first_of_image, in_if.data_byte});
      if (cfg_fire) begin
        case (cfg_if.index)
          REG_ROW_BYTES:   row_bytes_reg   = cfg_if.data[ROW_BYTES_W-1:0];
          REG_PIXEL_BYTES: pixel_bytes_reg = cfg_if.data[PIXEL_BYTES_W-1:0];
          default: ;
        endcase
      end
      if (out_fire) begin
        if (recon_q.size() == 0) begin
          flag_mismatch("unexpected word (none pending), recon_byte", 0, out_if.recon_byte);
        end else begin
          e = recon_q.pop_front();
          if (out_if.recon_byte !== e.recon)
            flag_mismatch("recon_byte", e.recon, out_if.recon_byte);
          if (out_if.row_end !== e.row_end)
            flag_mismatch("row_end", e.row_end, out_if.row_end);
        end
      end
      if (in_fire || out_fire || cfg_fire) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // driver and receiver: change inputs at the falling edge
  always @(negedge clk_i) begin
    scan_word_t w;
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    if (in_fire || !in_if.valid) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_if.valid          <= 1'b1;
        in_if.data_byte      <= w.data;
        in_if.first_of_image <= w.first;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  task automatic push_word(bit first, logic [BYTE_W-1:0] data);
    pending_words.push_back({first, data});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_if.valid || recon_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random_phase(int n_items);
    logic [ROW_BYTES_W-1:0]   rb;
    logic [PIXEL_BYTES_W-1:0] pix;
    int unsigned              rlen, nbytes;
    bit                       start;
    wait_quiet();
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0:       rb = '0;
        1, 2:    rb = ROW_BYTES_W'($urandom_range(13, 64));
        default: rb = ROW_BYTES_W'($urandom_range(1, 12));
      endcase
      write_reg(REG_ROW_BYTES, rb);
    end
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 9))
        0:       pix = '0;
        1:       pix = PIXEL_BYTES_W'($urandom_range(HIST_DEPTH + 1, {PIXEL_BYTES_W{1'b1}}));
        default: pix = PIXEL_BYTES_W'($urandom_range(1, HIST_DEPTH));
      endcase
      write_reg(REG_PIXEL_BYTES, {(CFG_DATA_W - PIXEL_BYTES_W)'($urandom), pix});
    end
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_PIXEL_BYTES + 1, REG_LAST_IDX)),
                CFG_DATA_W'($urandom));
    rlen = eff_row_len(row_bytes_reg);
    // rows longer than anything written so far must not read the line buffer
    start = (!top_row && rlen > buf_filled) || ($urandom_range(0, 1) == 1);
    while (n_items > 0) begin
      push_word(start, pick_filter());
      nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rlen - 1) : rlen;
      repeat (nbytes) push_word($urandom_range(0, 79) == 0, pick_data());
      n_items -= nbytes + 1;
      start = (nbytes < rlen) ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    in_if.valid          = 1'b0;
    in_if.data_byte      = '0;
    in_if.first_of_image = 1'b0;
    out_if.ready         = 1'b0;
    cfg_if.valid         = 1'b0;
    cfg_if.index         = '0;
    cfg_if.data          = '0;
    row_bytes_reg        = ROW_BYTES_RST;
    pixel_bytes_reg      = PIXEL_BYTES_RST;
    cur_filter           = FILT_NONE;
    await_filter         = 1'b1;
    top_row              = 1'b1;
    col                  = 0;
    buf_filled           = 0;
    in_fire              = 1'b0;
    idle_cycles          = 0;
    err_count            = 0;
    send_idle_pct        = 31;
    recv_idle_pct        = 76;
    clear_windows();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // every filter over two-byte rows, extremes, image restart mid-row
    write_reg(REG_ROW_BYTES, CFG_DATA_W'(2));
    write_reg(REG_PIXEL_BYTES, CFG_DATA_W'(1));
    push_word(1'b1, FILT_NONE);      push_word(1'b0, 8'h00); push_word(1'b0, 8'hFF);
    push_word(1'b0, FILT_SUB);       push_word(1'b0, 8'hFF); push_word(1'b0, 8'h01);
    push_word(1'b0, FILT_UP);        push_word(1'b0, 8'h01); push_word(1'b0, 8'hFF);
    push_word(1'b0, FILT_AVG);       push_word(1'b0, 8'hFF); push_word(1'b0, 8'hFF);
    push_word(1'b0, FILT_PAETH);     push_word(1'b0, 8'h80); push_word(1'b0, 8'h7F);
    push_word(1'b0, BYTE_W'(FILT_PAETH + 1));
    push_word(1'b0, 8'h12); push_word(1'b0, 8'h34);
    push_word(1'b0, FILT_TOP_CODE);  push_word(1'b0, 8'h56); push_word(1'b0, 8'h78);
    push_word(1'b0, FILT_PAETH);     push_word(1'b0, 8'hFF);
    push_word(1'b1, FILT_SUB);       push_word(1'b0, 8'h10);
    wait_quiet();

    // shrink the row while mid-row: the next byte closes it
    write_reg(REG_ROW_BYTES, CFG_DATA_W'(1));
    write_reg(REG_PIXEL_BYTES, '0);
    push_word(1'b0, 8'h20);
    push_word(1'b0, FILT_SUB);
    push_word(1'b0, 8'h33);
    wait_quiet();

    // zero row length and oversized pixel distance
    write_reg(REG_ROW_BYTES, '0);
    write_reg(REG_PIXEL_BYTES, CFG_DATA_W'({PIXEL_BYTES_W{1'b1}}));
    push_word(1'b0, FILT_PAETH);
    push_word(1'b0, 8'h9A);

    repeat (3) run_random_phase(PHASE_ITEMS);

    send_idle_pct = 76;
    recv_idle_pct = 31;
    repeat (3) run_random_phase(PHASE_ITEMS);

    wait_quiet();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // oversized row length clamps to a full line buffer: no row end early on
    write_reg(REG_ROW_BYTES, '1);
    write_reg(REG_PIXEL_BYTES, CFG_DATA_W'(HIST_DEPTH));
    push_word(1'b1, FILT_PAETH);
    repeat (LONG_ROW_PART) push_word(1'b0, pick_data());
    wait_quiet();
    // back to a short row: the next byte closes the long one
    write_reg(REG_ROW_BYTES, CFG_DATA_W'(12));
    push_word(1'b0, pick_data());
    push_word(1'b0, FILT_AVG);
    repeat (4) push_word(1'b0, pick_data());
    repeat (3) run_random_phase(PHASE_ITEMS);

    wait_quiet();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
